// ===== rtl/arm_inverse_kinematics_assert.svh =====
// Assertion macros for the arm inverse kinematics block
`ifndef ARM_INVERSE_KINEMATICS_ASSERT_SVH
`define ARM_INVERSE_KINEMATICS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AIK_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AIK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AIK_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define AIK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/aik_pkg.sv =====
package aik_pkg;

    // angle width, Q3.29 with headroom for sums of three angles
    localparam int ANG_W = 35;
    // CORDIC datapath width
    localparam int CW = 45;
    localparam int CORDIC_STEPS = 30;
    localparam int CFG_IDX_W = 4;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 35'sd843314857;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LEN  = 4'd0,
        CFG_UPPER_LEN  = 4'd1,
        CFG_GAIN_BASE  = 4'd2,
        CFG_GAIN_LOWER = 4'd3,
        CFG_GAIN_UPPER = 4'd4,
        CFG_BIAS_BASE  = 4'd5,
        CFG_BIAS_LOWER = 4'd6,
        CFG_BIAS_UPPER = 4'd7
    } t_cfg_idx;

    // arctangent of 2^-i, Q3.29, rounded
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 35'sd421657428;
            5'd1:  v = 35'sd248918915;
            5'd2:  v = 35'sd131521918;
            5'd3:  v = 35'sd66762579;
            5'd4:  v = 35'sd33510843;
            5'd5:  v = 35'sd16771758;
            5'd6:  v = 35'sd8387925;
            5'd7:  v = 35'sd4194219;
            5'd8:  v = 35'sd2097141;
            5'd9:  v = 35'sd1048575;
            5'd10: v = 35'sd524288;
            5'd11: v = 35'sd262144;
            5'd12: v = 35'sd131072;
            5'd13: v = 35'sd65536;
            5'd14: v = 35'sd32768;
            5'd15: v = 35'sd16384;
            5'd16: v = 35'sd8192;
            5'd17: v = 35'sd4096;
            5'd18: v = 35'sd2048;
            5'd19: v = 35'sd1024;
            5'd20: v = 35'sd512;
            5'd21: v = 35'sd256;
            5'd22: v = 35'sd128;
            5'd23: v = 35'sd64;
            5'd24: v = 35'sd32;
            5'd25: v = 35'sd16;
            5'd26: v = 35'sd8;
            5'd27: v = 35'sd4;
            5'd28: v = 35'sd2;
            5'd29: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a 33-bit sum to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/aik_if.sv =====
// target point channel
interface aik_target_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

// motor position channel
interface aik_solution_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] base_position;
    logic signed [31:0] lower_position;
    logic signed [31:0] upper_position;
    logic               reachable;
    modport source (output valid, output base_position, output lower_position,
                    output upper_position, output reachable, input ready);
    modport sink   (input valid, input base_position, input lower_position,
                    input upper_position, input reachable, output ready);
endinterface

// register write channel
interface aik_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aik_pkg::CFG_IDX_W-1:0]    index;
    logic [31:0]                      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/arm_inverse_kinematics.sv =====
// Channel      Dir  Handshake     Carries
// i_target     in   valid/ready   target_x, target_y, target_z
// o_solution   out  valid/ready   base/lower/upper_position, reachable
// i_cfg        in   valid/ready   index, data (register write)
//
// The work is done by the shared CORDIC loop (30 steps for each of five angles)
// and the 32-step square root unit (three roots); one 33x33 multiplier serves all.
// i_target is ready only while idle; a finished item waits in the output register.
// Reset (i_rst_n low, synchronous) loads register defaults and zeroes held positions.
`include "arm_inverse_kinematics_assert.svh"

module arm_inverse_kinematics (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    aik_target_if.sink             i_target,
    aik_solution_if.source         o_solution,
    aik_cfg_if.sink                i_cfg
);

    localparam int CW    = aik_pkg::CW;
    localparam int ANG_W = aik_pkg::ANG_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_L1, ST_SQ_L2, ST_LSQ,
        ST_D1_ISSUE, ST_D2_ISSUE, ST_D1_TAKE, ST_D2_TAKE, ST_M1_TAKE, ST_M2_TAKE,
        ST_CHECK, ST_SQRT_LOAD, ST_SQRT_RUN, ST_CO_LOAD, ST_CO_NORM, ST_CO_PRE,
        ST_CO_RUN, ST_CO_STORE, ST_PM_LO, ST_PM_HI, ST_PM_ACC1, ST_PM_ACC2,
        ST_PM_FIN, ST_UNREACH, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [14:0]        r_l1, r_l2;
    logic signed [31:0] r_gain_b, r_gain_l, r_gain_u;
    logic signed [31:0] r_bias_b, r_bias_l, r_bias_u;
    // held positions
    logic signed [31:0] r_last_b, r_last_l, r_last_u;

    // working values
    logic signed [15:0] r_x, r_y, r_z;
    logic [31:0]        r_rr, r_r2;
    logic [29:0]        r_l1sq, r_l2sq;
    logic signed [34:0] r_n1, r_n2;
    logic [63:0]        r_d1, r_d2;
    logic               r_ok1, r_ok2;
    logic [31:0]        r_s1, r_s2;
    logic [23:0]        r_rho;
    logic [4:0]         r_cnt;
    logic [2:0]         r_job;

    // shared multiplier
    logic signed [32:0] r_ma, r_mb;
    logic signed [65:0] r_mp;

    // square root unit
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [63:0] sq_t, n_sq_v, n_sq_res;

    // CORDIC unit
    logic signed [CW-1:0]    r_cn, r_cd;
    logic signed [ANG_W-1:0] r_cz;
    logic signed [CW-1:0]    co_num, co_den, co_dn, co_dd;
    logic [CW-1:0]           co_an, co_ad, co_m;
    logic signed [ANG_W-1:0] co_tab;

    // angles and position accumulator
    logic signed [ANG_W-1:0] r_a1, r_a2, r_ab, r_al, r_au;
    logic signed [66:0]      r_acc;
    logic signed [ANG_W-1:0] pm_ang;
    logic signed [31:0]      pm_gain, pm_bias;
    logic signed [32:0]      pm_sum;
    logic signed [31:0]      pm_pos;
    logic                    r_reach;

    // magnitudes of the acos numerators
    logic [34:0] mag1, mag2;
    logic signed [34:0] n_n1, n_n2;

    // output register
    logic               r_o_valid, r_o_reach;
    logic signed [31:0] r_o_b, r_o_l, r_o_u;

    assign i_target.ready            = (r_state == ST_IDLE);
    assign i_cfg.ready               = 1'b1;
    assign o_solution.valid          = r_o_valid;
    assign o_solution.base_position  = r_o_b;
    assign o_solution.lower_position = r_o_l;
    assign o_solution.upper_position = r_o_u;
    assign o_solution.reachable      = r_o_reach;

    // multiplier: product registered, ready in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_mp <= r_ma * r_mb;
    end

    // numerators r2 +/- (L1^2 - L2^2); l2^2 arrives on the multiplier output
    always_comb begin
        n_n1 = $signed({3'b0, r_r2}) + $signed({5'b0, r_l1sq}) - $signed({5'b0, r_mp[29:0]});
        n_n2 = $signed({3'b0, r_r2}) + $signed({5'b0, r_mp[29:0]}) - $signed({5'b0, r_l1sq});
        mag1 = r_n1[34] ? 35'(-r_n1) : r_n1;
        mag2 = r_n2[34] ? 35'(-r_n2) : r_n2;
    end

    // square root step
    always_comb begin
        sq_t = r_sq_res + r_sq_bit;
        if (r_sq_v >= sq_t) begin
            n_sq_v   = r_sq_v - sq_t;
            n_sq_res = (r_sq_res >> 1) + r_sq_bit;
        end else begin
            n_sq_v   = r_sq_v;
            n_sq_res = r_sq_res >> 1;
        end
    end

    // CORDIC operand select and step terms
    always_comb begin
        case (r_job)
            3'd1: begin
                co_num = {13'b0, r_s2};
                co_den = {{10{r_n2[34]}}, r_n2};
            end
            3'd2: begin
                co_num = {{29{r_x[15]}}, r_x};
                co_den = {{29{r_y[15]}}, r_y};
            end
            3'd3: begin
                co_num = {21'b0, r_rho};
                co_den = {{21{r_z[15]}}, r_z, 8'b0};
            end
            3'd4: begin
                co_num = {{21{r_z[15]}}, r_z, 8'b0};
                co_den = {21'b0, r_rho};
            end
            default: begin
                co_num = {13'b0, r_s1};
                co_den = {{10{r_n1[34]}}, r_n1};
            end
        endcase
        co_an  = r_cn[CW-1] ? CW'(-r_cn) : r_cn;
        co_ad  = r_cd[CW-1] ? CW'(-r_cd) : r_cd;
        co_m   = co_an | co_ad;
        co_dn  = r_cn >>> r_cnt;
        co_dd  = r_cd >>> r_cnt;
        co_tab = aik_pkg::atan_tab(r_cnt);
    end

    // per-motor selection and final rounding
    always_comb begin
        case (r_job)
            3'd1: begin
                pm_ang  = r_al;
                pm_gain = r_gain_l;
                pm_bias = r_bias_l;
            end
            3'd2: begin
                pm_ang  = r_au;
                pm_gain = r_gain_u;
                pm_bias = r_bias_u;
            end
            default: begin
                pm_ang  = r_ab;
                pm_gain = r_gain_b;
                pm_bias = r_bias_b;
            end
        endcase
        pm_sum = $signed({{11{r_acc[66]}}, r_acc[66:45]}) + $signed({pm_bias[31], pm_bias});
        pm_pos = aik_pkg::sat32(pm_sum);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_l1      <= 15'd3200;
            r_l2      <= 15'd3200;
            r_gain_b  <= 32'sd65536;
            r_gain_l  <= 32'sd65536;
            r_gain_u  <= 32'sd65536;
            r_bias_b  <= '0;
            r_bias_l  <= '0;
            r_bias_u  <= '0;
            r_last_b  <= '0;
            r_last_l  <= '0;
            r_last_u  <= '0;
        end else begin
            // register writes
            if (i_cfg.valid) begin
                unique case (aik_pkg::t_cfg_idx'(i_cfg.index))
                    aik_pkg::CFG_LOWER_LEN:  r_l1     <= i_cfg.data[14:0];
                    aik_pkg::CFG_UPPER_LEN:  r_l2     <= i_cfg.data[14:0];
                    aik_pkg::CFG_GAIN_BASE:  r_gain_b <= i_cfg.data;
                    aik_pkg::CFG_GAIN_LOWER: r_gain_l <= i_cfg.data;
                    aik_pkg::CFG_GAIN_UPPER: r_gain_u <= i_cfg.data;
                    aik_pkg::CFG_BIAS_BASE:  r_bias_b <= i_cfg.data;
                    aik_pkg::CFG_BIAS_LOWER: r_bias_l <= i_cfg.data;
                    aik_pkg::CFG_BIAS_UPPER: r_bias_u <= i_cfg.data;
                    default: ;
                endcase
            end

            // output slot drains; in ST_OUT the slot is refilled instead
            if (r_o_valid && o_solution.ready && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_target.valid) begin
                        r_x     <= i_target.target_x;
                        r_y     <= i_target.target_y;
                        r_z     <= i_target.target_z;
                        r_state <= ST_SQ_X;
                    end
                end
                // squares of the coordinates and links
                ST_SQ_X: begin
                    r_ma    <= {{17{r_x[15]}}, r_x};
                    r_mb    <= {{17{r_x[15]}}, r_x};
                    r_state <= ST_SQ_Y;
                end
                ST_SQ_Y: begin
                    r_ma    <= {{17{r_y[15]}}, r_y};
                    r_mb    <= {{17{r_y[15]}}, r_y};
                    r_state <= ST_SQ_Z;
                end
                ST_SQ_Z: begin
                    r_rr    <= r_mp[31:0];
                    r_ma    <= {{17{r_z[15]}}, r_z};
                    r_mb    <= {{17{r_z[15]}}, r_z};
                    r_state <= ST_SQ_L1;
                end
                ST_SQ_L1: begin
                    r_rr    <= r_rr + r_mp[31:0];
                    r_ma    <= {18'b0, r_l1};
                    r_mb    <= {18'b0, r_l1};
                    r_state <= ST_SQ_L2;
                end
                ST_SQ_L2: begin
                    r_r2    <= r_rr + r_mp[31:0];
                    r_ma    <= {18'b0, r_l2};
                    r_mb    <= {18'b0, r_l2};
                    r_state <= ST_LSQ;
                end
                ST_LSQ: begin
                    r_l1sq  <= r_mp[29:0];
                    r_state <= ST_D1_ISSUE;
                end
                // d^2 = 4 L^2 r2 for both links
                ST_D1_ISSUE: begin
                    r_l2sq  <= r_mp[29:0];
                    r_n1    <= n_n1;
                    r_n2    <= n_n2;
                    r_ma    <= {3'b0, r_l1sq};
                    r_mb    <= {1'b0, r_r2};
                    r_state <= ST_D2_ISSUE;
                end
                ST_D2_ISSUE: begin
                    r_ma    <= {3'b0, r_l2sq};
                    r_mb    <= {1'b0, r_r2};
                    r_state <= ST_D1_TAKE;
                end
                ST_D1_TAKE: begin
                    r_d1    <= {r_mp[61:0], 2'b00};
                    r_ma    <= {1'b0, mag1[31:0]};
                    r_mb    <= {1'b0, mag1[31:0]};
                    r_state <= ST_D2_TAKE;
                end
                ST_D2_TAKE: begin
                    r_d2    <= {r_mp[61:0], 2'b00};
                    r_ma    <= {1'b0, mag2[31:0]};
                    r_mb    <= {1'b0, mag2[31:0]};
                    r_state <= ST_M1_TAKE;
                end
                // reach tests; keep the radicands d^2 - n^2
                ST_M1_TAKE: begin
                    r_ok1   <= (r_d1 != '0) && (mag1[34:32] == '0) && (r_mp[63:0] <= r_d1);
                    r_d1    <= r_d1 - r_mp[63:0];
                    r_state <= ST_M2_TAKE;
                end
                ST_M2_TAKE: begin
                    r_ok2   <= (r_d2 != '0) && (mag2[34:32] == '0) && (r_mp[63:0] <= r_d2);
                    r_d2    <= r_d2 - r_mp[63:0];
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_job   <= '0;
                    r_state <= (r_ok1 && r_ok2) ? ST_SQRT_LOAD : ST_UNREACH;
                end
                // square roots: two radicands, then rho
                ST_SQRT_LOAD: begin
                    case (r_job)
                        3'd0:    r_sq_v <= r_d1;
                        3'd1:    r_sq_v <= r_d2;
                        default: r_sq_v <= {16'b0, r_rr, 16'b0};
                    endcase
                    r_sq_res <= '0;
                    r_sq_bit <= 64'h4000_0000_0000_0000;
                    r_cnt    <= '0;
                    r_state  <= ST_SQRT_RUN;
                end
                ST_SQRT_RUN: begin
                    r_sq_v   <= n_sq_v;
                    r_sq_res <= n_sq_res;
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        case (r_job)
                            3'd0:    r_s1  <= n_sq_res[31:0];
                            3'd1:    r_s2  <= n_sq_res[31:0];
                            default: r_rho <= n_sq_res[23:0];
                        endcase
                        if (r_job == 3'd2) begin
                            r_job   <= '0;
                            r_state <= ST_CO_LOAD;
                        end else begin
                            r_job   <= r_job + 3'd1;
                            r_state <= ST_SQRT_LOAD;
                        end
                    end
                end
                // atan2 jobs: acos1, acos2, base, atan2(rho,z), atan2(z,rho)
                ST_CO_LOAD: begin
                    r_cn    <= co_num;
                    r_cd    <= co_den;
                    r_cz    <= '0;
                    r_state <= (co_num == '0 && co_den == '0) ? ST_CO_STORE : ST_CO_NORM;
                end
                ST_CO_NORM: begin
                    if (|co_m[CW-1:40]) begin
                        r_state <= ST_CO_PRE;
                    end else if (co_m[39:36] == '0) begin
                        r_cn <= r_cn <<< 4;
                        r_cd <= r_cd <<< 4;
                    end else begin
                        r_cn <= r_cn <<< 1;
                        r_cd <= r_cd <<< 1;
                    end
                end
                ST_CO_PRE: begin
                    // fold the left half plane by a quarter turn
                    if (r_cd < 0) begin
                        if (r_cn >= 0) begin
                            r_cd <= r_cn;
                            r_cn <= -r_cd;
                            r_cz <= aik_pkg::HALF_PI_Q;
                        end else begin
                            r_cd <= -r_cn;
                            r_cn <= r_cd;
                            r_cz <= -aik_pkg::HALF_PI_Q;
                        end
                    end
                    r_cnt   <= '0;
                    r_state <= ST_CO_RUN;
                end
                ST_CO_RUN: begin
                    if (r_cn > 0) begin
                        r_cd <= r_cd + co_dn;
                        r_cn <= r_cn - co_dd;
                        r_cz <= r_cz + co_tab;
                    end else begin
                        r_cd <= r_cd - co_dn;
                        r_cn <= r_cn + co_dd;
                        r_cz <= r_cz - co_tab;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(aik_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= ST_CO_STORE;
                    end
                end
                ST_CO_STORE: begin
                    case (r_job)
                        3'd0:    r_a1 <= r_cz;
                        3'd1:    r_a2 <= r_cz;
                        3'd2:    r_ab <= r_cz;
                        3'd3:    r_al <= aik_pkg::HALF_PI_Q - r_cz - r_a1;
                        default: r_au <= r_cz + r_a2 - aik_pkg::HALF_PI_Q;
                    endcase
                    if (r_job == 3'd4) begin
                        r_job   <= '0;
                        r_state <= ST_PM_LO;
                    end else begin
                        r_job   <= r_job + 3'd1;
                        r_state <= ST_CO_LOAD;
                    end
                end
                // angle * gain in two partial products, then round and bias
                ST_PM_LO: begin
                    r_ma    <= {16'b0, pm_ang[16:0]};
                    r_mb    <= {pm_gain[31], pm_gain};
                    r_state <= ST_PM_HI;
                end
                ST_PM_HI: begin
                    r_ma    <= {{15{pm_ang[34]}}, pm_ang[34:17]};
                    r_state <= ST_PM_ACC1;
                end
                ST_PM_ACC1: begin
                    r_acc   <= {r_mp[65], r_mp} + 67'sh1000_0000_0000;
                    r_state <= ST_PM_ACC2;
                end
                ST_PM_ACC2: begin
                    r_acc   <= r_acc + $signed({r_mp[49:0], 17'b0});
                    r_state <= ST_PM_FIN;
                end
                ST_PM_FIN: begin
                    case (r_job)
                        3'd0:    r_last_b <= pm_pos;
                        3'd1:    r_last_l <= pm_pos;
                        default: r_last_u <= pm_pos;
                    endcase
                    if (r_job == 3'd2) begin
                        r_reach <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        r_job   <= r_job + 3'd1;
                        r_state <= ST_PM_LO;
                    end
                end
                // unreachable: hold, base drifts by its bias
                ST_UNREACH: begin
                    r_last_b <= aik_pkg::sat32($signed({r_last_b[31], r_last_b})
                                               + $signed({r_bias_b[31], r_bias_b}));
                    r_reach  <= 1'b0;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_o_valid || o_solution.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_b     <= r_last_b;
                        r_o_l     <= r_last_l;
                        r_o_u     <= r_last_u;
                        r_o_reach <= r_reach;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `AIK_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_target.valid && i_target.ready, !i_target.ready, "item accepted but block still ready")
    `AIK_ASSERT_IMPL(a_cordic_count, i_clk, i_rst_n, r_state == ST_CO_RUN, r_cnt < 5'(aik_pkg::CORDIC_STEPS), "CORDIC step count out of range")
    `AIK_ASSERT_NEXT(a_hold_pitch, i_clk, i_rst_n, r_state == ST_UNREACH, r_last_l == $past(r_last_l) && r_last_u == $past(r_last_u) && !r_reach, "pitch positions not held on unreachable point")

endmodule
